// ----- rtl/b64d_pkg.sv -----
// Shared types, constants and the character map of the base64 decoder.
package b64d_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int CNT_OUT_W = 16;
	localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX = '1;

	typedef logic [6:0] code_t;

	localparam code_t CODE_INVALID = 7'h7F;
	localparam code_t CODE_PLUS = 7'd62;
	localparam code_t CODE_SLASH = 7'd63;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] LOWER_OFFSET = 8'd26;
	localparam logic [7:0] DIGIT_OFFSET = 8'd52;

	typedef struct packed {
		logic fire;
		logic stop;
		logic [1:0] num;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
	} grp_t;

	function automatic code_t char_code(input logic [7:0] c);
		code_t r;
		r = CODE_INVALID;
		case (c) inside
			[CHAR_UPPER_A:CHAR_UPPER_Z]: r = code_t'(c - CHAR_UPPER_A);
			[CHAR_LOWER_A:CHAR_LOWER_Z]: r = code_t'(c - CHAR_LOWER_A + LOWER_OFFSET);
			[CHAR_DIGIT_0:CHAR_DIGIT_9]: r = code_t'(c - CHAR_DIGIT_0 + DIGIT_OFFSET);
			CHAR_PLUS: r = CODE_PLUS;
			CHAR_SLASH: r = CODE_SLASH;
			default: r = CODE_INVALID;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/b64d_group.sv -----
// Character mapping and decoding of one group of four codes into up to three bytes.
module b64d_group import b64d_pkg::*; (
	input logic [7:0] in_char,
	input logic last_char,
	input logic [1:0] pos,
	input code_t [2:0] held,
	input logic stopped,
	output code_t code,
	output grp_t grp
);

	code_t c0, c1, c2, c3;
	logic v2, v3;
	logic [7:0] b0, b1, b2;

	always_comb begin
		code = char_code(in_char);
		c0 = (pos == 2'd0) ? code : held[0];
		c1 = (pos > 2'd1) ? held[1] : ((pos == 2'd1) ? code : CODE_INVALID);
		c2 = (pos > 2'd2) ? held[2] : ((pos == 2'd2) ? code : CODE_INVALID);
		c3 = (pos == 2'd3) ? code : CODE_INVALID;
		v2 = (c2 != CODE_INVALID);
		v3 = (c3 != CODE_INVALID);
		b0 = {c0[5:0], c1[5:4]};
		b1 = {c1[3:0], c2[5:2]};
		b2 = {c2[1:0], c3[5:0]};
		grp.fire = !stopped && ((pos == 2'd3) || last_char);
		grp.stop = grp.fire && ((c0 == CODE_INVALID) || (c1 == CODE_INVALID));
		grp.num = (grp.fire && !grp.stop) ? (2'd1 + 2'(v2) + 2'(v3)) : 2'd0;
		grp.byte0 = b0;
		grp.byte1 = v2 ? b1 : b2;
		grp.byte2 = b2;
	end

endmodule

// ----- rtl/base64_decoder.sv -----
// Top level of the streaming base64 decoder.
// The decoder takes one base64 character per cycle unless stalled and returns the decoded
// bytes one per cycle while out_ready is high. A character that completes a group of four,
// or is marked last, loads up to three bytes into the result register at once; they leave
// in turn while characters of the next group that produce no bytes keep being accepted. A
// character that produces bytes waits only until the final byte of the previous group is
// taken, so with out_ready high a steady stream runs at one character per cycle with three
// bytes out per four characters. The last character of a message always yields a result
// with end_of_message set, byte_valid low if it gave no byte; the group state then resets.
module base64_decoder import b64d_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] in_char,
	input logic last_char,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_byte,
	output logic byte_valid,
	output logic last_of_run,
	output logic end_of_message,
	output logic [CNT_OUT_W-1:0] byte_count
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	logic [1:0] pos_q;
	code_t [2:0] held_q;
	logic stopped_q;
	logic [COUNT_WIDTH-1:0] total_q;

	logic [2:0][7:0] res_byte_q;
	logic [2:0][CNT_OUT_W-1:0] res_cnt_q;
	logic [1:0] res_num_q;
	logic [1:0] res_idx_q;
	logic res_empty_q;
	logic res_eom_q;

	code_t code;
	grp_t grp;
	logic [COUNT_WIDTH-1:0] t1, t2, t3, new_total;
	logic emits, drain_ok, accept, last_res;

	function automatic logic [CNT_OUT_W-1:0] clamp(input logic [COUNT_WIDTH-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'(CNT_OUT_MAX)) ? CNT_OUT_MAX : w[CNT_OUT_W-1:0];
	endfunction

	b64d_group u_group (
		.in_char (in_char),
		.last_char (last_char),
		.pos (pos_q),
		.held (held_q),
		.stopped (stopped_q),
		.code (code),
		.grp (grp)
	);

	always_comb begin
		t1 = (total_q == CNT_MAX) ? total_q : total_q + CNT_ONE;
		t2 = (t1 == CNT_MAX) ? t1 : t1 + CNT_ONE;
		t3 = (t2 == CNT_MAX) ? t2 : t2 + CNT_ONE;
		case (grp.num)
			2'd1: new_total = t1;
			2'd2: new_total = t2;
			2'd3: new_total = t3;
			default: new_total = total_q;
		endcase
	end

	assign last_res = (res_idx_q == (res_num_q - 2'd1));
	assign drain_ok = (res_num_q == 2'd0) || (out_ready && last_res);
	assign emits = (grp.num != 2'd0) || last_char;
	assign in_ready = drain_ok || !emits;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			held_q <= '0;
			stopped_q <= 1'b0;
			total_q <= '0;
		end else if (accept) begin
			if (last_char) begin
				pos_q <= 2'd0;
				held_q <= '0;
				stopped_q <= 1'b0;
				total_q <= '0;
			end else if (!stopped_q) begin
				if (grp.fire) begin
					pos_q <= 2'd0;
					held_q <= '0;
					stopped_q <= grp.stop;
					total_q <= new_total;
				end else begin
					held_q[pos_q] <= code;
					pos_q <= pos_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_num_q <= 2'd0;
			res_idx_q <= 2'd0;
			res_empty_q <= 1'b0;
			res_eom_q <= 1'b0;
		end else if (accept && emits) begin
			res_num_q <= (grp.num == 2'd0) ? 2'd1 : grp.num;
			res_idx_q <= 2'd0;
			res_empty_q <= (grp.num == 2'd0);
			res_eom_q <= last_char;
		end else if (out_valid && out_ready) begin
			if (last_res) begin
				res_num_q <= 2'd0;
				res_idx_q <= 2'd0;
			end else begin
				res_idx_q <= res_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emits) begin
			if (grp.num == 2'd0) begin
				res_byte_q[0] <= 8'd0;
				res_cnt_q[0] <= clamp(total_q);
			end else begin
				res_byte_q <= {grp.byte2, grp.byte1, grp.byte0};
				res_cnt_q <= {clamp(t3), clamp(t2), clamp(t1)};
			end
		end
	end

	always_comb begin
		case (res_idx_q)
			2'd1: begin
				out_byte = res_byte_q[1];
				byte_count = res_cnt_q[1];
			end
			2'd2: begin
				out_byte = res_byte_q[2];
				byte_count = res_cnt_q[2];
			end
			default: begin
				out_byte = res_byte_q[0];
				byte_count = res_cnt_q[0];
			end
		endcase
	end

	assign out_valid = (res_num_q != 2'd0);
	assign byte_valid = !res_empty_q;
	assign last_of_run = last_res;
	assign end_of_message = res_eom_q && last_res;

	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> end_of_message && last_of_run)
		else $error("empty result without end of message");

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> res_idx_q < res_num_q)
		else $error("result index beyond run length");

	a_msg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_char |=> pos_q == 2'd0 && !stopped_q && total_q == '0)
		else $error("state not cleared after last character");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emits && out_valid |-> out_ready && last_res)
		else $error("new run loaded over pending results");

endmodule
